### sv/silu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silu_pkg
// Shared widths, fixed-point constants and sideband type for the SiLU
// activation pipeline.
// ----------------------------------------------------------------------------
package silu_pkg;

    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = 16;
    localparam int MAG_W     = DATA_W;

    // internal Q30 arithmetic
    localparam int              Q_BITS = 30;
    localparam longint unsigned Q_ONE  = 64'd1 << Q_BITS;
    localparam longint unsigned LN2_Q  = 64'd744261118;

    localparam int EXP_TERMS = 16;

    // range reduction
    localparam int              A_SHIFT = Q_BITS - FRAC_BITS;
    localparam int              A_W     = MAG_W + A_SHIFT;
    localparam longint unsigned A_MAX   = (64'd1 << (DATA_W - 1)) << A_SHIFT;
    localparam int              K_LIMIT = 62;
    localparam int              K_FULL  = int'(A_MAX / LN2_Q);
    localparam int              K_NUM   = (K_FULL < K_LIMIT) ? K_FULL : K_LIMIT;
    localparam int              K_W     = $clog2(K_NUM + 1);
    localparam bit              ZERO_EN = (K_NUM == K_LIMIT);

    // series and exponent
    localparam int T_W   = Q_BITS;
    localparam int E_W   = Q_BITS + 1;
    localparam int SUM_W = Q_BITS + 2;

    // reciprocal divider
    localparam int              D_W          = Q_BITS + 2;
    localparam int              QUO_W        = 32;
    localparam int              DIV_STEPS    = 2;
    localparam int              DIV_STAGES   = QUO_W / DIV_STEPS;
    localparam longint unsigned DIV_REM_INIT = 64'd1 << (2 * Q_BITS - QUO_W);

    // sigmoid and product
    localparam int              S_W     = Q_BITS + 1;
    localparam int              M_W     = MAG_W + 1;
    localparam longint unsigned RND_Q   = 64'd1 << (Q_BITS - 1);
    localparam longint unsigned POS_LIM = (64'd1 << (DATA_W - 1)) - 64'd1;
    localparam longint unsigned NEG_LIM = 64'd1 << (DATA_W - 1);

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic             last;
    } side_t;

endpackage

### sv/silu_exp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silu_exp_unit
// Pipelined exp(-|x|) in Q30: range reduction by ln2, a truncated series
// with one multiply stage and one reciprocal-divide stage per term, then
// the final shift by the reduction count.
// ----------------------------------------------------------------------------
module silu_exp_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  silu_pkg::side_t          in_side,
    output logic                     out_valid,
    output logic [silu_pkg::E_W-1:0] out_exp,
    output silu_pkg::side_t          out_side
);
    import silu_pkg::*;

    localparam int  NT       = EXP_TERMS - 2;
    localparam bit  SUB_LAST = ((EXP_TERMS - 1) % 2) == 1;

    typedef struct packed {
        logic [T_W-1:0]          r;
        logic [K_W-1:0]          k;
        logic                    zero;
        logic signed [SUM_W-1:0] sum;
        side_t                   side;
    } ctx_t;

    // range compare
    logic [A_W-1:0]   a_in;
    logic [K_NUM-1:0] ge_next;
    logic             v0_reg;
    logic [A_W-1:0]   a0_reg;
    logic [K_NUM-1:0] ge0_reg;
    side_t            side0_reg;

    // reduction
    logic [K_W-1:0] k_sel;
    logic [A_W-1:0] base_sel;
    ctx_t           ctx1_next;
    logic           v1_reg;
    ctx_t           ctx1_reg;

    // series
    logic [NT-1:0]  mv_reg;
    logic [T_W-1:0] mq_reg [NT];
    ctx_t           mctx_reg [NT];
    logic [NT-1:0]  dv_reg;
    logic [T_W-1:0] dt_reg [NT];
    ctx_t           dctx_reg [NT];

    // final
    logic signed [SUM_W-1:0] sum_fin;
    logic [E_W-1:0]          sum_pos;
    logic [E_W-1:0]          exp_next;
    logic                    ev_reg;
    logic [E_W-1:0]          exp_reg;
    side_t                   eside_reg;

    assign a_in = A_W'(in_side.mag) << A_SHIFT;

    always_comb
    begin
        for (int j = 0; j < K_NUM; j++)
        begin
            ge_next[j] = (a_in >= A_W'(LN2_Q * 64'(j + 1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            ev_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            ev_reg <= dv_reg[NT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg    <= a_in;
            ge0_reg   <= ge_next;
            side0_reg <= in_side;
            ctx1_reg  <= ctx1_next;
            exp_reg   <= exp_next;
            eside_reg <= dctx_reg[NT-1].side;
        end
    end

    // thermometer of compares gives k, the matching multiple gives r
    always_comb
    begin
        k_sel    = '0;
        base_sel = '0;
        for (int j = 0; j < K_NUM; j++)
        begin
            if (ge0_reg[j])
            begin
                k_sel    = K_W'(j + 1);
                base_sel = A_W'(LN2_Q * 64'(j + 1));
            end
        end
        ctx1_next.r    = T_W'(a0_reg - base_sel);
        ctx1_next.k    = k_sel;
        ctx1_next.zero = ge0_reg[K_NUM-1] & ZERO_EN;
        ctx1_next.sum  = SUM_W'(Q_ONE);
        ctx1_next.side = side0_reg;
    end

    generate
        for (genvar i = 0; i < NT; i++)
        begin : g_term
            localparam int              N       = i + 2;
            localparam int              L       = $clog2(N);
            localparam int              RECIP_W = T_W + 1;
            localparam longint unsigned Recip   = ((64'd1 << (T_W + L)) + 64'(N) - 64'd1) / 64'(N);
            localparam bit              SubPrev = ((N - 1) % 2) == 1;

            logic [T_W-1:0]         t_prev;
            ctx_t                   c_prev;
            logic                   v_prev;
            logic [2*T_W-1:0]       tr_prod;
            ctx_t                   mctx_next;
            logic [T_W+RECIP_W-1:0] qd_prod;

            if (i == 0)
            begin : g_first
                assign t_prev = ctx1_reg.r;
                assign c_prev = ctx1_reg;
                assign v_prev = v1_reg;
            end
            else
            begin : g_rest
                assign t_prev = dt_reg[i-1];
                assign c_prev = dctx_reg[i-1];
                assign v_prev = dv_reg[i-1];
            end

            assign tr_prod = t_prev * c_prev.r;

            always_comb
            begin
                mctx_next = c_prev;
                if (SubPrev)
                begin
                    mctx_next.sum = c_prev.sum - $signed(SUM_W'(t_prev));
                end
                else
                begin
                    mctx_next.sum = c_prev.sum + $signed(SUM_W'(t_prev));
                end
            end

            // exact floor division by n through a rounded-up reciprocal
            assign qd_prod = mq_reg[i] * RECIP_W'(Recip);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mv_reg[i] <= 1'b0;
                    dv_reg[i] <= 1'b0;
                end
                else if (adv)
                begin
                    mv_reg[i] <= v_prev;
                    dv_reg[i] <= mv_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    mq_reg[i]   <= T_W'(tr_prod >> Q_BITS);
                    mctx_reg[i] <= mctx_next;
                    dt_reg[i]   <= T_W'(qd_prod >> (T_W + L));
                    dctx_reg[i] <= mctx_reg[i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (SUB_LAST)
        begin
            sum_fin = dctx_reg[NT-1].sum - $signed(SUM_W'(dt_reg[NT-1]));
        end
        else
        begin
            sum_fin = dctx_reg[NT-1].sum + $signed(SUM_W'(dt_reg[NT-1]));
        end
        sum_pos  = sum_fin[SUM_W-1] ? '0 : E_W'(sum_fin);
        exp_next = dctx_reg[NT-1].zero ? '0 : (sum_pos >> dctx_reg[NT-1].k);
    end

    assign out_valid = ev_reg;
    assign out_exp   = exp_reg;
    assign out_side  = eside_reg;

endmodule

### sv/silu_recip_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silu_recip_div
// Pipelined restoring divider for 2^60 / (2^30 + e), two quotient bits per
// stage; gives the quotient and a nonzero-remainder flag.
// ----------------------------------------------------------------------------
module silu_recip_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [silu_pkg::E_W-1:0] in_exp,
    input  silu_pkg::side_t          in_side,
    output logic                     out_valid,
    output logic [silu_pkg::S_W-1:0] out_quo,
    output logic                     out_rem_nz,
    output silu_pkg::side_t          out_side
);
    import silu_pkg::*;

    logic [DIV_STAGES:0] v_reg;
    logic [D_W-1:0]      den_reg [DIV_STAGES+1];
    logic [D_W-1:0]      rem_reg [DIV_STAGES+1];
    logic [QUO_W-1:0]    quo_reg [DIV_STAGES+1];
    side_t               side_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DIV_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= D_W'(Q_ONE) + D_W'(in_exp);
            rem_reg[0]  <= D_W'(DIV_REM_INIT);
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    generate
        for (genvar s = 1; s <= DIV_STAGES; s++)
        begin : g_step
            logic [D_W-1:0]   rem_w;
            logic [QUO_W-1:0] quo_w;
            logic [D_W:0]     sh_w;

            always_comb
            begin
                rem_w = rem_reg[s-1];
                quo_w = quo_reg[s-1];
                sh_w  = '0;
                for (int j = 0; j < DIV_STEPS; j++)
                begin
                    sh_w = {rem_w, 1'b0};
                    if (sh_w >= {1'b0, den_reg[s-1]})
                    begin
                        rem_w = D_W'(sh_w - {1'b0, den_reg[s-1]});
                        quo_w = {quo_w[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_w = D_W'(sh_w);
                        quo_w = {quo_w[QUO_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    den_reg[s]  <= den_reg[s-1];
                    rem_reg[s]  <= rem_w;
                    quo_reg[s]  <= quo_w;
                    side_reg[s] <= side_reg[s-1];
                end
            end
        end
    endgenerate

    assign out_valid  = v_reg[DIV_STAGES];
    assign out_quo    = S_W'(quo_reg[DIV_STAGES]);
    assign out_rem_nz = |rem_reg[DIV_STAGES];
    assign out_side   = side_reg[DIV_STAGES];

endmodule

### sv/silu_activation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silu_activation
// SiLU (swish) on signed Q4.12 samples: x * sigmoid(x), rounded to nearest
// and saturated, with an end-of-vector flag carried alongside.
//
//   channel      handshake                          payload
//   sample       sample_valid / sample_ready        sample[15:0], last_in
//   activation   activation_valid / activation_ready activation[15:0], last_out
//
// one transaction per cycle sustained while the output is not stalled; the
// pipe has 31 exp stages, 17 divider stages and 3 output stages
// all pipeline stages advance together; a spare register behind the output
// register takes one result when the output stalls, then the pipe holds
// reset clears only valid bits; no clearing pass, no state between items
// ----------------------------------------------------------------------------
module silu_activation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic signed [silu_pkg::DATA_W-1:0] sample,
    input  logic                             last_in,
    output logic                             activation_valid,
    input  logic                             activation_ready,
    output logic signed [silu_pkg::DATA_W-1:0] activation,
    output logic                             last_out
);
    import silu_pkg::*;

    logic             adv;
    logic             in_fire;
    logic [MAG_W-1:0] raw;
    side_t            in_side;

    logic           exp_valid;
    logic [E_W-1:0] exp_val;
    side_t          exp_side;

    logic           div_valid;
    logic [S_W-1:0] div_quo;
    logic           div_rem_nz;
    side_t          div_side;

    logic [S_W-1:0]         s_next;
    logic                   sv_reg;
    logic [S_W-1:0]         s_reg;
    side_t                  sside_reg;
    logic [MAG_W+S_W-1:0]   prod;
    logic                   mv_reg;
    logic [M_W-1:0]         m_reg;
    side_t                  mside_reg;

    logic [DATA_W-1:0] y_next;
    logic              push;
    logic              act_valid_reg;
    logic [DATA_W-1:0] act_reg;
    logic              last_reg;
    logic              spare_valid_reg;
    logic [DATA_W-1:0] spare_act_reg;
    logic              spare_last_reg;

    assign adv          = ~spare_valid_reg;
    assign sample_ready = adv;
    assign in_fire      = sample_valid & adv;

    assign raw          = sample;
    assign in_side.neg  = raw[MAG_W-1];
    assign in_side.mag  = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
    assign in_side.last = last_in;

    silu_exp_unit u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_fire),
        .in_side   (in_side),
        .out_valid (exp_valid),
        .out_exp   (exp_val),
        .out_side  (exp_side)
    );

    silu_recip_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (exp_valid),
        .in_exp     (exp_val),
        .in_side    (exp_side),
        .out_valid  (div_valid),
        .out_quo    (div_quo),
        .out_rem_nz (div_rem_nz),
        .out_side   (div_side)
    );

    // negative inputs use e/(1+e) = 1 - ceil(1/(1+e))
    assign s_next = div_side.neg ? (S_W'(Q_ONE) - div_quo - S_W'(div_rem_nz)) : div_quo;
    assign prod   = (MAG_W+S_W)'(sside_reg.mag) * (MAG_W+S_W)'(s_reg)
                  + (MAG_W+S_W)'(RND_Q);

    always_comb
    begin
        if (mside_reg.neg)
        begin
            y_next = (m_reg > M_W'(NEG_LIM)) ? DATA_W'(NEG_LIM) : DATA_W'(~m_reg + 1'b1);
        end
        else
        begin
            y_next = (m_reg > M_W'(POS_LIM)) ? DATA_W'(POS_LIM) : DATA_W'(m_reg);
        end
    end

    assign push = mv_reg & adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg          <= 1'b0;
            mv_reg          <= 1'b0;
            act_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                sv_reg <= div_valid;
                mv_reg <= sv_reg;
            end
            if (!act_valid_reg || activation_ready)
            begin
                if (spare_valid_reg)
                begin
                    act_valid_reg   <= 1'b1;
                    spare_valid_reg <= 1'b0;
                end
                else
                begin
                    act_valid_reg <= push;
                end
            end
            else if (push)
            begin
                spare_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg     <= s_next;
            sside_reg <= div_side;
            m_reg     <= M_W'(prod >> Q_BITS);
            mside_reg <= sside_reg;
        end
        if (!act_valid_reg || activation_ready)
        begin
            if (spare_valid_reg)
            begin
                act_reg  <= spare_act_reg;
                last_reg <= spare_last_reg;
            end
            else
            begin
                act_reg  <= y_next;
                last_reg <= mside_reg.last;
            end
        end
        else if (push)
        begin
            spare_act_reg  <= y_next;
            spare_last_reg <= mside_reg.last;
        end
    end

    assign activation_valid = act_valid_reg;
    assign activation       = act_reg;
    assign last_out         = last_reg;

    // spare register only ever holds a result behind a waiting output
    a_spare_behind_output : assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> act_valid_reg)
        else $error("spare result without a pending output");

    a_spare_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(spare_valid_reg) |-> $past(act_valid_reg && !activation_ready))
        else $error("spare register filled without an output stall");

    a_exp_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid |-> (exp_val <= E_W'(Q_ONE)))
        else $error("exp result above one");

    a_mag_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        mv_reg |-> (m_reg <= M_W'(mside_reg.mag)))
        else $error("silu magnitude above input magnitude");

endmodule

### tb/silu_activation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silu_activation_tb
// Self-checking bench for the SiLU activation pipeline. A bit-exact integer
// model of x * sigmoid(x) predicts each activation when the sample
// transaction is accepted. Every activation transaction is compared in order
// against that prediction, along with the end-of-vector flag. Directed
// corner samples run first, then random samples in phases with no idling,
// heavy sender gaps, heavy output stalls and light mixed idling.
// ----------------------------------------------------------------------------
module silu_activation_tb;

    localparam int              DW          = silu_pkg::DATA_W;
    localparam int              FRAC        = 12;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam int              SERIES_LEN  = 16;
    localparam int              DRAIN_WAIT  = 64;
    localparam int              IDLE_LIMIT  = 4000;
    localparam int              PHASE_ITEMS = 470;

    typedef struct {
        logic signed [DW-1:0] sample;
        logic signed [DW-1:0] activation;
        logic                 last;
    } silu_result_t;

    class silu_scoreboard;
        silu_result_t pending_results[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function logic signed [DW-1:0] silu_q12(logic signed [DW-1:0] x);
            longint unsigned mag;
            longint unsigned a;
            longint unsigned k;
            longint unsigned r;
            longint unsigned term;
            longint unsigned e;
            longint unsigned den;
            longint unsigned s;
            longint unsigned m;
            longint          sum;
            longint          y;
            logic            neg;
            neg = x[DW-1];
            mag = neg ? longint'(-longint'(x)) : longint'(x);
            a = mag << (30 - FRAC);
            k = a / LN2_Q30;
            r = a - k * LN2_Q30;
            term = ONE_Q30;
            sum = longint'(ONE_Q30);
            for (int n = 1; n < SERIES_LEN; n++)
            begin
                term = ((term * r) >> 30) / longint'(n);
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (k >= 62)
                e = 0;
            else
                e = longint'(sum) >> k;
            den = ONE_Q30 + e;
            if (neg)
                s = (e << 30) / den;
            else
                s = (64'd1 << 60) / den;
            m = (mag * s + (64'd1 << 29)) >> 30;
            y = neg ? -longint'(m) : longint'(m);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            return y[DW-1:0];
        endfunction

        function void record_sample(logic signed [DW-1:0] x, logic last);
            silu_result_t res;
            res.sample     = x;
            res.activation = silu_q12(x);
            res.last       = last;
            pending_results.push_back(res);
        endfunction

        function void check_activation(logic signed [DW-1:0] act, logic last);
            silu_result_t res;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected activation %0d last %0b", act, last);
                return;
            end
            res = pending_results.pop_front();
            if (act !== res.activation || last !== res.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch for sample %0d: expected %0d last %0b, got %0d last %0b",
                             res.sample, res.activation, res.last, act, last);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_ready;
    logic signed [DW-1:0] sample;
    logic                 last_in;
    logic                 activation_valid;
    logic                 activation_ready;
    logic signed [DW-1:0] activation;
    logic                 last_out;

    silu_scoreboard sb;
    int             stall_pct;
    int             idle_cycles;

    silu_activation DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .sample           (sample),
        .last_in          (last_in),
        .activation_valid (activation_valid),
        .activation_ready (activation_ready),
        .activation       (activation),
        .last_out         (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        activation_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            activation_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if (sample_valid && sample_ready)
                sb.record_sample(sample, last_in);
            if (activation_valid && activation_ready)
                sb.check_activation(activation, last_out);
            if ((sample_valid && sample_ready) || (activation_valid && activation_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("silu_activation_tb: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input logic signed [DW-1:0] x, input logic last,
                               input int gap);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= x;
        last_in      <= last;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    task automatic wait_for_drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    function automatic logic signed [DW-1:0] random_sample();
        case ($urandom_range(3))
            0:       return DW'($urandom);
            1:       return DW'(int'($urandom_range(510)) - 255);
            default: return DW'(int'($urandom_range(24576)) - 12288);
        endcase
    endfunction

    task automatic run_phase(input int count, input int idle_pct, input int stall);
        int gap;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            gap = 0;
            while ($urandom_range(99) < idle_pct)
                gap++;
            send_sample(random_sample(), ($urandom_range(7) == 0), gap);
        end
        wait_for_drain();
    endtask

    initial
    begin
        logic signed [DW-1:0] corners[$];
        sb           = new();
        stall_pct    = 0;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        last_in      <= 1'b0;
        corners = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, -16'sd2, 16'sd12, -16'sd12,
                    16'sd2839, -16'sd2839, 16'sd4096, -16'sd4096, 16'sd8192,
                    -16'sd8192, 16'sd16384, -16'sd16384, 16'sd21845, -16'sd21846,
                    16'sd32766, -16'sd32767, 16'sd32767, -16'sd32768};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner samples
        foreach (corners[i])
            send_sample(corners[i], i[0], 0);
        wait_for_drain();

        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 82, 0);
        run_phase(PHASE_ITEMS, 0, 82);
        run_phase(PHASE_ITEMS, 23, 23);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("silu_activation_tb: PASS");
        else
            $display("silu_activation_tb: FAIL");
        $finish;
    end

endmodule
